// File: design/pairs_spread_signal_engine_unit_macros.svh
// assertion macros shared by the pairs spread signal engine
`ifndef PAIRS_SPREAD_SIGNAL_ENGINE_UNIT_MACROS_SVH
`define PAIRS_SPREAD_SIGNAL_ENGINE_UNIT_MACROS_SVH
// same-cycle implication
`define PSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: design/pss_pkg.sv
// types, constants and helpers of the pairs spread signal engine
package pss_pkg;

    localparam int NUM_PAIRS   = 64;
    localparam int SLOT_W      = $clog2(NUM_PAIRS);
    localparam int IN_W        = 392;
    localparam int OUT_W       = 144;
    localparam int DIV_W       = 80;
    localparam int DEN_W       = 49;
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [47:0] QTY_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [CNT_W-1:0] CNT_Z   = 7'd56;
    localparam logic [CNT_W-1:0] CNT_IMB = 7'd64;
    localparam logic [CNT_W-1:0] CNT_Q1  = 7'd72;
    localparam logic [CNT_W-1:0] CNT_Q2  = 7'd80;

    localparam logic [2:0] CFG_ENTRY      = 3'd0;
    localparam logic [2:0] CFG_EXIT       = 3'd1;
    localparam logic [2:0] CFG_SAFE       = 3'd2;
    localparam logic [2:0] CFG_IMB_LONG   = 3'd3;
    localparam logic [2:0] CFG_IMB_SHORT  = 3'd4;
    localparam logic [2:0] CFG_BET        = 3'd5;

    localparam logic [31:0] RST_ENTRY     = 32'd131072;
    localparam logic [31:0] RST_EXIT      = 32'd32768;
    localparam logic [31:0] RST_SAFE      = 32'd1638400;
    localparam logic [17:0] RST_IMB_LONG  = 18'h3CCCD;
    localparam logic [17:0] RST_IMB_SHORT = 18'd13107;
    localparam logic [47:0] RST_BET       = 48'd65536000;

    typedef enum logic [1:0] {ST_EVAL, ST_MISSING, ST_UNSAFE, ST_ZERO_DEV} status_t;
    typedef enum logic [1:0] {ACT_NONE, ACT_SHORT, ACT_LONG, ACT_EXIT} action_t;
    typedef enum logic [1:0] {DIR_FLAT, DIR_SHORT, DIR_LONG} dir_t;

    typedef enum logic [4:0] {
        B_IDLE, B_NORM, B_SQR, B_LNM, B_HMUL, B_DIFF, B_ZSTART, B_ZWAIT,
        B_ISTART, B_IWAIT, B_DECIDE, B_Q1START, B_Q1WAIT, B_BM0, B_BM1,
        B_Q2START, B_Q2WAIT, B_OUT
    } back_state_t;

    typedef struct packed {
        logic [31:0] entry_threshold;
        logic [31:0] exit_threshold;
        logic [31:0] safe_limit;
        logic [17:0] imb_long_limit;
        logic [17:0] imb_short_limit;
        logic [47:0] bet_notional;
    } pss_cfg_t;

    typedef struct packed {
        logic [5:0]  pid;
        logic [47:0] p1;
        logic [47:0] p2;
        logic [31:0] h;
        logic [31:0] mean;
        logic [31:0] dev;
        logic [48:0] sum1;
        logic [47:0] dif1;
        logic        neg1;
        logic [48:0] sum2;
        logic [47:0] dif2;
        logic        neg2;
        status_t     status;
    } pss_item_t;

    typedef struct packed {
        logic [5:0]  pair_id;
        action_t     action;
        logic        leg1_sell;
        logic [47:0] leg1_quantity;
        logic        leg2_sell;
        logic [47:0] leg2_quantity;
        logic        reduce_only;
        logic [31:0] z_value;
        status_t     status;
    } pss_result_t;

    function automatic logic [47:0] qty_sat(input logic [DIV_W-1:0] q);
        qty_sat = (q[DIV_W-1:48] != '0) ? QTY_MAX : q[47:0];
    endfunction

endpackage

// File: design/pss_front.sv
// front end: accepts evaluations, screens prices and deviation, forms book sums
module pss_front import pss_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [IN_W-1:0] in_data,
    output logic            q_push,
    output pss_item_t       q_data,
    input  logic            q_full
);

    logic      stage_valid_reg;
    pss_item_t stage_reg;
    pss_item_t cls;
    logic [47:0] b1, a1, b2, a2;

    assign b1 = in_data[149:102];
    assign a1 = in_data[197:150];
    assign b2 = in_data[245:198];
    assign a2 = in_data[293:246];

    always_comb
    begin
        cls.pid  = in_data[5:0];
        cls.p1   = in_data[53:6];
        cls.p2   = in_data[101:54];
        cls.h    = in_data[325:294];
        cls.mean = in_data[357:326];
        cls.dev  = in_data[389:358];
        cls.sum1 = {1'b0, b1} + {1'b0, a1};
        cls.dif1 = (b1 >= a1) ? (b1 - a1) : (a1 - b1);
        cls.neg1 = (b1 < a1);
        cls.sum2 = {1'b0, b2} + {1'b0, a2};
        cls.dif2 = (b2 >= a2) ? (b2 - a2) : (a2 - b2);
        cls.neg2 = (b2 < a2);
        if (cls.p1 == '0 || cls.p2 == '0)
        begin
            cls.status = ST_MISSING;
        end
        else if (cls.dev == '0)
        begin
            cls.status = ST_ZERO_DEV;
        end
        else
        begin
            cls.status = ST_EVAL;
        end
    end

    assign q_push   = stage_valid_reg && !q_full;
    assign in_ready = !stage_valid_reg || !q_full;
    assign q_data   = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg <= cls;
        end
    end

endmodule

// File: design/pss_queue.sv
// short item queue between front and back
module pss_queue import pss_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pss_item_t push_data,
    input  logic      pop,
    output pss_item_t head,
    output logic      full,
    output logic      empty
);

    pss_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/pss_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module pss_div import pss_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [CNT_W-1:0] count,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] num_reg, quot_reg;
    logic [DEN_W-1:0] den_reg, rem_reg;
    logic [DEN_W:0]   rem_sh, rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, num_reg[DIV_W-1]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign done    = done_reg;
    assign quot    = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= count;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quot_reg <= {quot_reg[DIV_W-2:0], ge};
            num_reg  <= {num_reg[DIV_W-2:0], 1'b0};
        end
    end

endmodule

// File: design/pss_back.sv
// back end: logarithms, z-score, imbalances, position decision and quantities
module pss_back import pss_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  pss_cfg_t    cfg,
    input  logic        q_empty,
    input  pss_item_t   q_head,
    output logic        q_pop,
    output pss_result_t res,
    output logic        res_valid,
    input  logic        res_ready
);

    back_state_t state_reg, state_next;
    pss_item_t   item_reg;
    logic        leg_reg;
    logic [47:0] norm_reg;
    logic [5:0]  shift_reg;
    logic [30:0] mant_reg;
    logic [23:0] frac_reg;
    logic [4:0]  iter_reg;
    logic [31:0] ln1_reg, ln2_reg;
    logic [39:0] hlmag_reg;
    logic        hlneg_reg;
    logic [40:0] diff_reg;
    logic [55:0] zm_reg;
    logic [17:0] imb1_reg, imb2_reg;
    logic [47:0] q1_reg, q2_reg;
    logic [63:0] a0_reg;
    logic [47:0] a1_reg;
    action_t     act_reg;
    logic        s1_reg, s2_reg, ro_reg;
    status_t     status_reg;
    logic [31:0] zout_reg;
    pss_result_t res_reg;
    logic        res_valid_reg;

    dir_t                 pos_mem [NUM_PAIRS];
    logic [NUM_PAIRS-1:0] pos_valid_reg;
    dir_t                 pos_rd_reg;
    logic [SLOT_W-1:0]    slot;
    dir_t                 dir_cur;

    logic             div_start, div_done;
    logic [DIV_W-1:0] div_num, div_quot;
    logic [DEN_W-1:0] div_den;
    logic [CNT_W-1:0] div_count;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic [31:0] sq_t;
    logic [5:0]  kd;
    logic [29:0] l2_bits, l2_mag;
    logic [63:0] ln_rnd, hl_rnd;
    logic [31:0] ln_val, h_mag, ln2_mag;
    logic [40:0] hl41, d_mag;
    logic [48:0] imb_sum;
    logic [47:0] imb_dif;
    logic        imb_neg;
    logic [17:0] imb_val;
    logic        h_pos;
    logic [DIV_W-1:0] q2_num;

    logic signed [56:0] z57, en57, ex57, zmax57, zmin57;
    logic        unsafe;
    action_t     dec_act;
    logic        dec_s1, dec_s2, dec_ro, dec_wr;
    dir_t        dec_dir;
    logic [31:0] z_sat;

    pss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .count (div_count),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign mul_p = mul_a * mul_b;

    assign slot    = item_reg.pid[SLOT_W-1:0];
    assign dir_cur = pos_valid_reg[slot] ? pos_rd_reg : DIR_FLAT;

    // squaring step and log assembly
    assign sq_t    = mul_p[61:30];
    assign kd      = 6'd23 - shift_reg;
    assign l2_bits = {kd, frac_reg};
    assign l2_mag  = l2_bits[29] ? (~l2_bits + 30'd1) : l2_bits;
    assign ln_rnd  = mul_p + 64'h0000_0000_8000_0000;
    assign ln_val  = l2_bits[29] ? (~ln_rnd[63:32] + 32'd1) : ln_rnd[63:32];
    assign h_mag   = item_reg.h[31] ? (~item_reg.h + 32'd1) : item_reg.h;
    assign ln2_mag = ln2_reg[31] ? (~ln2_reg + 32'd1) : ln2_reg;
    assign hl_rnd  = mul_p + 64'h0000_0000_0080_0000;
    assign hl41    = hlneg_reg ? (~{1'b0, hlmag_reg} + 41'd1) : {1'b0, hlmag_reg};
    assign d_mag   = diff_reg[40] ? (~diff_reg + 41'd1) : diff_reg;
    assign h_pos   = !item_reg.h[31] && (item_reg.h != '0);
    assign q2_num  = {16'b0, a0_reg} + {a1_reg, 32'b0};

    assign imb_sum = leg_reg ? item_reg.sum2 : item_reg.sum1;
    assign imb_dif = leg_reg ? item_reg.dif2 : item_reg.dif1;
    assign imb_neg = leg_reg ? item_reg.neg2 : item_reg.neg1;
    assign imb_val = imb_neg ? (~{1'b0, div_quot[16:0]} + 18'd1) : {1'b0, div_quot[16:0]};

    // decision
    always_comb
    begin
        z57    = diff_reg[40] ? -$signed({1'b0, zm_reg}) : $signed({1'b0, zm_reg});
        en57   = $signed({25'b0, cfg.entry_threshold});
        ex57   = $signed({25'b0, cfg.exit_threshold});
        zmax57 = $signed({26'b0, 31'h7FFF_FFFF});
        zmin57 = $signed({{26{1'b1}}, 31'b0});
        unsafe = (zm_reg > {24'b0, cfg.safe_limit});
        if (z57 > zmax57)
        begin
            z_sat = 32'h7FFF_FFFF;
        end
        else if (z57 < zmin57)
        begin
            z_sat = 32'h8000_0000;
        end
        else
        begin
            z_sat = z57[31:0];
        end
        dec_act = ACT_NONE;
        dec_s1  = 1'b0;
        dec_s2  = 1'b0;
        dec_ro  = 1'b0;
        dec_wr  = 1'b0;
        dec_dir = DIR_FLAT;
        if (!unsafe)
        begin
            if (dir_cur == DIR_SHORT || dir_cur == DIR_LONG)
            begin
                if ((dir_cur == DIR_SHORT && z57 < ex57) ||
                    (dir_cur == DIR_LONG && z57 > -ex57))
                begin
                    dec_act = ACT_EXIT;
                    dec_ro  = 1'b1;
                    dec_s1  = (dir_cur == DIR_LONG);
                    dec_s2  = (dir_cur == DIR_SHORT);
                    dec_wr  = 1'b1;
                    dec_dir = DIR_FLAT;
                end
            end
            else if (z57 > en57 && $signed(imb1_reg) < $signed(cfg.imb_short_limit) &&
                     $signed(imb2_reg) > $signed(cfg.imb_long_limit))
            begin
                dec_act = ACT_SHORT;
                dec_s1  = 1'b1;
                dec_wr  = 1'b1;
                dec_dir = DIR_SHORT;
            end
            else if (z57 < -en57 && $signed(imb1_reg) > $signed(cfg.imb_long_limit) &&
                     $signed(imb2_reg) < $signed(cfg.imb_short_limit))
            begin
                dec_act = ACT_LONG;
                dec_s2  = 1'b1;
                dec_wr  = 1'b1;
                dec_dir = DIR_LONG;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        div_count  = '0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = (q_head.status == ST_EVAL) ? B_NORM : B_OUT;
                end
            end
            B_NORM:
            begin
                if (norm_reg[47])
                begin
                    state_next = B_SQR;
                end
            end
            B_SQR:
            begin
                mul_a = {1'b0, mant_reg};
                mul_b = {1'b0, mant_reg};
                if (iter_reg == 5'd23)
                begin
                    state_next = B_LNM;
                end
            end
            B_LNM:
            begin
                mul_a      = {2'b0, l2_mag};
                mul_b      = LN2_Q32;
                state_next = leg_reg ? B_HMUL : B_NORM;
            end
            B_HMUL:
            begin
                mul_a      = h_mag;
                mul_b      = ln2_mag;
                state_next = B_DIFF;
            end
            B_DIFF:
            begin
                state_next = B_ZSTART;
            end
            B_ZSTART:
            begin
                div_start  = 1'b1;
                div_num    = {d_mag[39:0], 40'b0};
                div_den    = {17'b0, item_reg.dev};
                div_count  = CNT_Z;
                state_next = B_ZWAIT;
            end
            B_ZWAIT:
            begin
                if (div_done)
                begin
                    state_next = B_ISTART;
                end
            end
            B_ISTART:
            begin
                if (imb_sum == '0)
                begin
                    state_next = leg_reg ? B_DECIDE : B_ISTART;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = {imb_dif, 32'b0};
                    div_den    = imb_sum;
                    div_count  = CNT_IMB;
                    state_next = B_IWAIT;
                end
            end
            B_IWAIT:
            begin
                if (div_done)
                begin
                    state_next = leg_reg ? B_DECIDE : B_ISTART;
                end
            end
            B_DECIDE:
            begin
                state_next = (dec_act != ACT_NONE) ? B_Q1START : B_OUT;
            end
            B_Q1START:
            begin
                div_start  = 1'b1;
                div_num    = {cfg.bet_notional, 32'b0};
                div_den    = {1'b0, item_reg.p1};
                div_count  = CNT_Q1;
                state_next = B_Q1WAIT;
            end
            B_Q1WAIT:
            begin
                if (div_done)
                begin
                    state_next = h_pos ? B_BM0 : B_OUT;
                end
            end
            B_BM0:
            begin
                mul_a      = cfg.bet_notional[31:0];
                mul_b      = item_reg.h;
                state_next = B_BM1;
            end
            B_BM1:
            begin
                mul_a      = {16'b0, cfg.bet_notional[47:32]};
                mul_b      = item_reg.h;
                state_next = B_Q2START;
            end
            B_Q2START:
            begin
                div_start  = 1'b1;
                div_num    = q2_num;
                div_den    = {1'b0, item_reg.p2};
                div_count  = CNT_Q2;
                state_next = B_Q2WAIT;
            end
            B_Q2WAIT:
            begin
                if (div_done)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                item_reg   <= q_head;
                leg_reg    <= 1'b0;
                norm_reg   <= q_head.p1;
                shift_reg  <= '0;
                act_reg    <= ACT_NONE;
                s1_reg     <= 1'b0;
                s2_reg     <= 1'b0;
                ro_reg     <= 1'b0;
                q1_reg     <= '0;
                q2_reg     <= '0;
                zout_reg   <= '0;
                imb1_reg   <= '0;
                imb2_reg   <= '0;
                status_reg <= q_head.status;
            end
            B_NORM:
            begin
                if (norm_reg[47:40] == '0)
                begin
                    norm_reg  <= {norm_reg[39:0], 8'b0};
                    shift_reg <= shift_reg + 6'd8;
                end
                else if (!norm_reg[47])
                begin
                    norm_reg  <= {norm_reg[46:0], 1'b0};
                    shift_reg <= shift_reg + 6'd1;
                end
                else
                begin
                    mant_reg <= norm_reg[47:17];
                    frac_reg <= '0;
                    iter_reg <= '0;
                end
            end
            B_SQR:
            begin
                mant_reg <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                frac_reg <= {frac_reg[22:0], sq_t[31]};
                iter_reg <= iter_reg + 5'd1;
            end
            B_LNM:
            begin
                if (leg_reg)
                begin
                    ln2_reg <= ln_val;
                end
                else
                begin
                    ln1_reg   <= ln_val;
                    leg_reg   <= 1'b1;
                    norm_reg  <= item_reg.p2;
                    shift_reg <= '0;
                end
            end
            B_HMUL:
            begin
                hlmag_reg <= hl_rnd[63:24];
                hlneg_reg <= item_reg.h[31] ^ ln2_reg[31];
            end
            B_DIFF:
            begin
                diff_reg <= {{9{ln1_reg[31]}}, ln1_reg} - hl41
                            - {{9{item_reg.mean[31]}}, item_reg.mean};
            end
            B_ZWAIT:
            begin
                if (div_done)
                begin
                    zm_reg  <= div_quot[55:0];
                    leg_reg <= 1'b0;
                end
            end
            B_ISTART:
            begin
                if (imb_sum == '0)
                begin
                    leg_reg <= 1'b1;
                end
            end
            B_IWAIT:
            begin
                if (div_done)
                begin
                    if (leg_reg)
                    begin
                        imb2_reg <= imb_val;
                    end
                    else
                    begin
                        imb1_reg <= imb_val;
                        leg_reg  <= 1'b1;
                    end
                end
            end
            B_DECIDE:
            begin
                act_reg    <= dec_act;
                s1_reg     <= dec_s1;
                s2_reg     <= dec_s2;
                ro_reg     <= dec_ro;
                zout_reg   <= z_sat;
                status_reg <= unsafe ? ST_UNSAFE : ST_EVAL;
            end
            B_Q1WAIT:
            begin
                if (div_done)
                begin
                    q1_reg <= qty_sat(div_quot);
                end
            end
            B_BM0:
            begin
                a0_reg <= mul_p;
            end
            B_BM1:
            begin
                a1_reg <= mul_p[47:0];
            end
            B_Q2WAIT:
            begin
                if (div_done)
                begin
                    q2_reg <= qty_sat(div_quot);
                end
            end
            default:
            begin
            end
        endcase
    end

    // position store
    always_ff @(posedge clk)
    begin
        pos_rd_reg <= pos_mem[slot];
        if (state_reg == B_DECIDE && dec_wr)
        begin
            pos_mem[slot] <= dec_dir;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= '0;
        end
        else if (state_reg == B_DECIDE && dec_wr)
        begin
            pos_valid_reg[slot] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (state_reg == B_OUT && (!res_valid_reg || res_ready))
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_OUT && (!res_valid_reg || res_ready))
        begin
            res_reg.pair_id       <= item_reg.pid;
            res_reg.action        <= act_reg;
            res_reg.leg1_sell     <= s1_reg;
            res_reg.leg1_quantity <= q1_reg;
            res_reg.leg2_sell     <= s2_reg;
            res_reg.leg2_quantity <= q2_reg;
            res_reg.reduce_only   <= ro_reg;
            res_reg.z_value       <= zout_reg;
            res_reg.status        <= status_reg;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// File: design/pairs_spread_signal_engine_unit.sv
// top level of the pairs spread signal engine
// Usage:
// s_axis carries one pair evaluation per item; m_axis returns exactly one
// result per item, in order. tuser on m_axis is the status code.
// cfg writes one of six registers by index; it is always ready and is meant
// to be used only while the block is idle. Indexes past the list are ignored.
// An item passes a one-stage front register and a two-entry queue, so the
// front keeps accepting while the back end works or the result waits, until
// both are full. A missing price or zero deviation goes straight to the
// output register. An evaluated item takes two logarithms, each by
// normalizing, squaring and a scaling step on the shared multiplier, then a
// hedge multiply and the bit-serial divider: for z, for each nonempty book
// imbalance and, with an order, for the leg1 quantity and, for a positive
// hedge, the leg2 quantity. The back end takes one item at a time and pops
// the next only after the last has reached the output register.
// Reset clears all positions to flat, restores register defaults and empties
// the queue. When the receiver stalls the result holds in the output
// register; the back end finishes the next item and then waits.
`include "pairs_spread_signal_engine_unit_macros.svh"

module pairs_spread_signal_engine_unit import pss_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // pair_index, leg1_price, leg2_price, leg1_bid_volume, leg1_ask_volume,
    // leg2_bid_volume, leg2_ask_volume, hedge, mean_spread, spread_deviation
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // pair_id, action, leg1_sell, leg1_quantity, leg2_sell, leg2_quantity,
    // reduce_only, z_value
    output logic [OUT_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]       m_axis_tuser,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [47:0]      cfg_data
);

    pss_cfg_t    cfg_reg;
    logic        q_push, q_pop, q_full, q_empty;
    pss_item_t   q_in, q_head;
    pss_result_t res;
    logic        res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_threshold <= RST_ENTRY;
            cfg_reg.exit_threshold  <= RST_EXIT;
            cfg_reg.safe_limit      <= RST_SAFE;
            cfg_reg.imb_long_limit  <= RST_IMB_LONG;
            cfg_reg.imb_short_limit <= RST_IMB_SHORT;
            cfg_reg.bet_notional    <= RST_BET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENTRY:     cfg_reg.entry_threshold <= cfg_data[31:0];
                CFG_EXIT:      cfg_reg.exit_threshold  <= cfg_data[31:0];
                CFG_SAFE:      cfg_reg.safe_limit      <= cfg_data[31:0];
                CFG_IMB_LONG:  cfg_reg.imb_long_limit  <= cfg_data[17:0];
                CFG_IMB_SHORT: cfg_reg.imb_short_limit <= cfg_data[17:0];
                CFG_BET:       cfg_reg.bet_notional    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    pss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = res.status;
    assign m_axis_tdata  = {5'b0, res.z_value, res.reduce_only, res.leg2_quantity,
                            res.leg2_sell, res.leg1_quantity, res.leg1_sell,
                            res.action, res.pair_id};

    `PSS_ASSERT_IMP(a_skip_no_order, res_valid && res.status != ST_EVAL, res.action == ACT_NONE && res.leg1_quantity == '0 && res.leg2_quantity == '0, "order on a skipped item")
    `PSS_ASSERT_IMP(a_reduce_exit, res_valid, res.reduce_only == (res.action == ACT_EXIT), "reduce_only does not match exit")
    `PSS_ASSERT_IMP(a_skip_zero_z, res_valid && (res.status == ST_MISSING || res.status == ST_ZERO_DEV), res.z_value == '0, "z not zero on a screened item")
    `PSS_ASSERT_NXT(a_queue_fill, q_push && !q_pop, !q_empty, "queue lost a pushed item")

endmodule
